/* rtl/ncg_pkg.sv */
// ----------------------------------------------------------------------------
// ncg_pkg
// shared constants, codes and payload types of the narrowphase contact core
// ----------------------------------------------------------------------------
package ncg_pkg;

   // fraction bits of the contact normal
   localparam int NFB       = 14;
   // quotient bits of a normal lane, dividend width of the normal divide
   localparam int QW        = NFB + 2;
   localparam int NW        = 32 + NFB;
   // square root unit: one result bit per stage
   localparam int ISQ_STEPS = 32;
   localparam int REMW      = 35;

   localparam logic [1:0] KIND_SS = 2'd0;
   localparam logic [1:0] KIND_SB = 2'd1;
   localparam logic [1:0] KIND_BB = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [31:0] PEN_MAX = 32'h7fff_ffff;
   localparam logic [QW-1:0] UNIT_ONE = {{(QW-NFB-1){1'b0}}, 1'b1, {NFB{1'b0}}};

   localparam logic [33:0] MAG_HI = 34'h0_8000_0000;

   typedef struct packed {
      logic [1:0]       kind;
      logic             hit;
      logic [31:0]      box_pen;
      logic [1:0]       box_axis;
      logic             box_neg;
      logic [31:0]      sr;
      logic [30:0]      as0;
      logic [2:0]       neg;
      logic             zero;
      logic [2:0][33:0] mag;
      logic [63:0]      d64;
      logic [31:0]      root1;
      logic [33:0]      rem1;
   } side_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] nx;
      logic [15:0] ny;
      logic [15:0] nz;
      logic [31:0] pen;
   } result_type;

endpackage

/* rtl/ncg_front.sv */
// ----------------------------------------------------------------------------
// ncg_front
// pair setup: offset vector, squared distance, hit test, box-box result
// ----------------------------------------------------------------------------
module ncg_front import ncg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [1:0]       in_kind,
   input  logic [2:0][31:0] in_off,
   input  logic [2:0][30:0] in_asz,
   input  logic [2:0][30:0] in_bsz,
   output logic             out_valid,
   output side_type         out_side
);

   logic [2:0][32:0] o_mag;
   logic [2:0][34:0] lo, hi, cc;
   logic [2:0][33:0] c_mag, p;
   logic [33:0]      p_sel;
   logic [33:0]      p_rnd;
   logic [1:0]       ax;
   side_type         a_side_in;

   logic             a_vld_ff, b_vld_ff, c_vld_ff;
   side_type         a_side_ff, b_side_ff, c_side_ff, c_side_in;
   logic [2:0][67:0] b_sq_ff;
   logic [63:0]      b_lim_ff;
   logic [31:0]      lim_op;
   logic [69:0]      s_sum;

   // stage a: vector and box overlap
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         o_mag[i] = in_off[i][31] ? 33'(-{in_off[i][31], in_off[i]})
                                  : {in_off[i][31], in_off[i]};
         lo[i] = {{2{in_off[i][31]}}, in_off[i], 1'b0} - {4'b0, in_bsz[i]};
         hi[i] = {{2{in_off[i][31]}}, in_off[i], 1'b0} + {4'b0, in_bsz[i]};
         if (!lo[i][34] && lo[i] != 35'd0) begin
            cc[i] = lo[i];
         end else if (hi[i][34]) begin
            cc[i] = hi[i];
         end else begin
            cc[i] = 35'd0;
         end
         c_mag[i] = cc[i][34] ? 34'(-cc[i]) : cc[i][33:0];
         p[i] = {2'b00, 32'({1'b0, in_asz[i]} + {1'b0, in_bsz[i]})} - {o_mag[i], 1'b0};
      end
      if ($signed(p[0]) < $signed(p[1]) && $signed(p[0]) < $signed(p[2])) begin
         ax = AXIS_X;
      end else if ($signed(p[1]) < $signed(p[0]) && $signed(p[1]) < $signed(p[2])) begin
         ax = AXIS_Y;
      end else begin
         ax = AXIS_Z;
      end
      p_sel = p[ax];
      p_rnd = p_sel + 34'd1;

      a_side_in          = '0;
      a_side_in.kind     = in_kind;
      a_side_in.hit      = !p[0][33] && !p[1][33] && !p[2][33];
      a_side_in.box_pen  = p_rnd[32:1];
      a_side_in.box_axis = ax;
      a_side_in.box_neg  = in_off[ax][31];
      a_side_in.sr       = {1'b0, in_asz[0]} + {1'b0, in_bsz[0]};
      a_side_in.as0      = in_asz[0];
      for (int i = 0; i < 3; i++) begin
         if (in_kind == KIND_SS) begin
            a_side_in.mag[i] = {1'b0, o_mag[i]};
            a_side_in.neg[i] = in_off[i][31];
         end else begin
            a_side_in.mag[i] = c_mag[i];
            a_side_in.neg[i] = cc[i][34];
         end
      end
   end

   // stage b: squares and hit limit
   assign lim_op = (a_side_ff.kind == KIND_SS) ? a_side_ff.sr : {a_side_ff.as0, 1'b0};

   // stage c: squared length and hit decision
   always_comb begin
      s_sum = 70'(b_sq_ff[0]) + 70'(b_sq_ff[1]) + 70'(b_sq_ff[2]);
      c_side_in      = b_side_ff;
      c_side_in.d64  = s_sum[63:0];
      c_side_in.zero = (s_sum == 70'd0);
      unique case (b_side_ff.kind) inside
         KIND_SS, KIND_SB: c_side_in.hit = (s_sum <= {6'b0, b_lim_ff});
         KIND_BB:          c_side_in.hit = b_side_ff.hit;
         default:          c_side_in.hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff <= a_side_in;
         b_side_ff <= a_side_ff;
         for (int i = 0; i < 3; i++) begin
            b_sq_ff[i] <= a_side_ff.mag[i] * a_side_ff.mag[i];
         end
         b_lim_ff  <= lim_op * lim_op;
         c_side_ff <= c_side_in;
      end
   end

   assign out_valid = c_vld_ff;
   assign out_side  = c_side_ff;

endmodule

/* rtl/ncg_norm.sv */
// ----------------------------------------------------------------------------
// ncg_norm
// scales the normal vector into [2^30, 2^31] and forms its squared length
// ----------------------------------------------------------------------------
module ncg_norm import ncg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  side_type    in_side,
   output logic        out_valid,
   output side_type    out_side,
   output logic [63:0] out_d2
);

   logic [4:0]       vld_ff;
   side_type         n1_side_ff, n2_side_ff, n3_side_ff, q1_side_ff, q2_side_ff;
   side_type         n1_in, n2_in, n3_in;
   logic [33:0]      n1_mx_ff, n2_mx_ff;
   logic [33:0]      mx1, mx2, mx3;
   logic [2:0][63:0] q1_sq_ff;
   logic [63:0]      q2_d2_ff;

   // right shifts, then the coarse left shifts, then the fine ones
   always_comb begin
      n1_in = in_side;
      mx1 = in_side.mag[0];
      if (in_side.mag[1] > mx1) mx1 = in_side.mag[1];
      if (in_side.mag[2] > mx1) mx1 = in_side.mag[2];
      for (int k = 0; k < 3; k++) begin
         if (mx1 > MAG_HI) begin
            mx1 = mx1 >> 1;
            for (int i = 0; i < 3; i++) n1_in.mag[i] = n1_in.mag[i] >> 1;
         end
      end
   end

   // a left shift by sh is taken while the top bit stays below bit 31
   always_comb begin
      int sh;
      n2_in = n1_side_ff;
      mx2 = n1_mx_ff;
      for (int k = 0; k < 2; k++) begin
         sh = 16 >> k;
         if (mx2 < (MAG_HI >> sh)) begin
            mx2 = mx2 << sh;
            for (int i = 0; i < 3; i++) n2_in.mag[i] = n2_in.mag[i] << sh;
         end
      end
   end

   always_comb begin
      int sh;
      n3_in = n2_side_ff;
      mx3 = n2_mx_ff;
      for (int k = 0; k < 3; k++) begin
         sh = 4 >> k;
         if (mx3 < (MAG_HI >> sh)) begin
            mx3 = mx3 << sh;
            for (int i = 0; i < 3; i++) n3_in.mag[i] = n3_in.mag[i] << sh;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n1_side_ff <= n1_in;
         n1_mx_ff   <= mx1;
         n2_side_ff <= n2_in;
         n2_mx_ff   <= mx2;
         n3_side_ff <= n3_in;
         q1_side_ff <= n3_side_ff;
         for (int i = 0; i < 3; i++) begin
            q1_sq_ff[i] <= n3_side_ff.mag[i][31:0] * n3_side_ff.mag[i][31:0];
         end
         q2_side_ff <= q1_side_ff;
         q2_d2_ff   <= q1_sq_ff[0] + q1_sq_ff[1] + q1_sq_ff[2];
      end
   end

   assign out_valid = vld_ff[4];
   assign out_side  = q2_side_ff;
   assign out_d2    = q2_d2_ff;

endmodule

/* rtl/ncg_isqrt.sv */
// ----------------------------------------------------------------------------
// ncg_isqrt
// two-lane pipelined floor square root of 64-bit values, with remainder
// ----------------------------------------------------------------------------
module ncg_isqrt import ncg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  side_type         in_side,
   input  logic [1:0][63:0] in_val,
   output logic             out_valid,
   output side_type         out_side,
   output logic [1:0][31:0] out_root,
   output logic [1:0][33:0] out_rem
);

   logic             vld_ff  [ISQ_STEPS];
   side_type         side_ff [ISQ_STEPS];
   logic [1:0][REMW-1:0] rem_ff  [ISQ_STEPS];
   logic [1:0][31:0]     root_ff [ISQ_STEPS];
   logic [1:0][63:0]     val_ff  [ISQ_STEPS];

   for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_stage
      logic                 vld_src;
      side_type             side_src;
      logic [1:0][REMW-1:0] rem_src, rem_in, rem_sh, trial;
      logic [1:0][31:0]     root_src, root_in;
      logic [1:0][63:0]     val_src, val_in;

      if (j == 0) begin : g_first
         assign vld_src  = in_valid;
         assign side_src = in_side;
         assign rem_src  = '0;
         assign root_src = '0;
         assign val_src  = in_val;
      end else begin : g_next
         assign vld_src  = vld_ff[j-1];
         assign side_src = side_ff[j-1];
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
         assign val_src  = val_ff[j-1];
      end

      // bring down two bits, try (root << 2) | 1
      always_comb begin
         for (int l = 0; l < 2; l++) begin
            rem_sh[l] = {rem_src[l][REMW-3:0], val_src[l][63:62]};
            trial[l]  = {1'b0, root_src[l], 2'b01};
            if (rem_sh[l] >= trial[l]) begin
               rem_in[l]  = rem_sh[l] - trial[l];
               root_in[l] = {root_src[l][30:0], 1'b1};
            end else begin
               rem_in[l]  = rem_sh[l];
               root_in[l] = {root_src[l][30:0], 1'b0};
            end
            val_in[l] = {val_src[l][61:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[j] <= side_src;
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            val_ff[j]  <= val_in;
         end
      end
   end

   assign out_valid   = vld_ff[ISQ_STEPS-1];
   assign out_side    = side_ff[ISQ_STEPS-1];
   assign out_root    = root_ff[ISQ_STEPS-1];
   assign out_rem[0]  = rem_ff[ISQ_STEPS-1][0][33:0];
   assign out_rem[1]  = rem_ff[ISQ_STEPS-1][1][33:0];

endmodule

/* rtl/ncg_div.sv */
// ----------------------------------------------------------------------------
// ncg_div
// three-lane pipelined rounded divide of normal components by the length
// ----------------------------------------------------------------------------
module ncg_div import ncg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  side_type           in_side,
   input  logic [2:0][31:0]   in_num,
   input  logic [31:0]        in_den,
   output logic               out_valid,
   output side_type           out_side,
   output logic [2:0][QW-1:0] out_quo
);

   logic               vld_ff  [QW];
   side_type           side_ff [QW];
   logic [31:0]        den_ff  [QW];
   logic [2:0][31:0]   rem_ff  [QW];
   logic [2:0][QW-1:0] nlo_ff  [QW];
   logic [2:0][QW-1:0] quo_ff  [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic               vld_src;
      side_type           side_src;
      logic [31:0]        den_src;
      logic [2:0][31:0]   rem_src, rem_in;
      logic [2:0][QW-1:0] nlo_src, nlo_in, quo_src, quo_in;
      logic [2:0][32:0]   rem_sh;

      if (k == 0) begin : g_first
         logic [2:0][NW-1:0] n_full;
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               n_full[l]  = (NW'(in_num[l]) << NFB) + NW'(in_den >> 1);
               rem_src[l] = 32'(n_full[l][NW-1:QW]);
               nlo_src[l] = n_full[l][QW-1:0];
            end
         end
         assign vld_src  = in_valid;
         assign side_src = in_side;
         assign den_src  = in_den;
         assign quo_src  = '0;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign side_src = side_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign nlo_src  = nlo_ff[k-1];
         assign quo_src  = quo_ff[k-1];
      end

      // one restoring step per stage and lane
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            rem_sh[l] = {rem_src[l], nlo_src[l][QW-1]};
            if (rem_sh[l] >= {1'b0, den_src}) begin
               rem_in[l] = 32'(rem_sh[l] - {1'b0, den_src});
               quo_in[l] = {quo_src[l][QW-2:0], 1'b1};
            end else begin
               rem_in[l] = rem_sh[l][31:0];
               quo_in[l] = {quo_src[l][QW-2:0], 1'b0};
            end
            nlo_in[l] = {nlo_src[l][QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_src;
            den_ff[k]  <= den_src;
            rem_ff[k]  <= rem_in;
            nlo_ff[k]  <= nlo_in;
            quo_ff[k]  <= quo_in;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_side  = side_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];

endmodule

/* rtl/narrowphase_contact_generator_core.sv */
// ----------------------------------------------------------------------------
// narrowphase_contact_generator_core
// contact test, normal and penetration for sphere and axis-aligned box pairs
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata                               | tuser
//  ---------+-----------+-------------------------------------+-------------
//  req      | in        | offset x/y/z, a size x/y/z,         | pair kind
//           |           | b size x/y/z                        |
//  rsp      | out       | normal x/y/z, penetration           | hit
//
//  one beat in and one beat out per cycle while the output queue is not
//  full; a req beat passes 3 setup, 5 normalize, 32 square root, 16 divide
//  and 1 result stage, then the output queue
//  the square root stages and the normal divide stages set the latency
//  reset (synchronous, active high) clears all valid bits and the queue
//  the pipeline advances as one; it halts only while the two-entry output
//  queue is full, so a stall loses and repeats nothing
//
module narrowphase_contact_generator_core import ncg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // offset_x, offset_y, offset_z, a_size_x, a_size_y, a_size_z,
   // b_size_x, b_size_y, b_size_z, zero fill
   input  logic [287:0] req_tdata,
   // cmd
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // normal_x, normal_y, normal_z, penetration
   output logic [79:0]  rsp_tdata,
   // hit
   output logic [0:0]   rsp_tuser
);

   logic             en;
   logic [2:0][31:0] off;
   logic [2:0][30:0] asz, bsz;

   logic             fr_vld, nm_vld, sq_vld, dv_vld;
   side_type         fr_side, nm_side, sq_side, sq_side_mid, dv_side;
   logic [63:0]      nm_d2;
   logic [1:0][63:0] sq_val;
   logic [1:0][31:0] sq_root;
   logic [1:0][33:0] sq_rem;
   logic [2:0][31:0] dv_num;
   logic [2:0][QW-1:0] dv_quo;

   result_type       res_in, res_ff;
   logic             res_vld_ff;
   result_type       q0_ff, q1_ff;
   logic [1:0]       cnt_ff;
   logic             push, pop;

   // input unpack
   assign off[0] = req_tdata[31:0];
   assign off[1] = req_tdata[63:32];
   assign off[2] = req_tdata[95:64];
   assign asz[0] = req_tdata[126:96];
   assign asz[1] = req_tdata[157:127];
   assign asz[2] = req_tdata[188:158];
   assign bsz[0] = req_tdata[219:189];
   assign bsz[1] = req_tdata[250:220];
   assign bsz[2] = req_tdata[281:251];

   // whole pipe moves unless the output queue is full
   assign en         = (cnt_ff != 2'd2);
   assign req_tready = en;

   ncg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_kind   (req_tuser),
      .in_off    (off),
      .in_asz    (asz),
      .in_bsz    (bsz),
      .out_valid (fr_vld),
      .out_side  (fr_side)
   );

   ncg_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_vld),
      .in_side   (fr_side),
      .out_valid (nm_vld),
      .out_side  (nm_side),
      .out_d2    (nm_d2)
   );

   // lane 0: distance for penetration, lane 1: length of the scaled normal
   assign sq_val[0] = nm_side.d64;
   assign sq_val[1] = nm_d2;

   ncg_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (nm_vld),
      .in_side   (nm_side),
      .in_val    (sq_val),
      .out_valid (sq_vld),
      .out_side  (sq_side),
      .out_root  (sq_root),
      .out_rem   (sq_rem)
   );

   always_comb begin
      sq_side_mid       = sq_side;
      sq_side_mid.root1 = sq_root[0];
      sq_side_mid.rem1  = sq_rem[0];
      for (int i = 0; i < 3; i++) dv_num[i] = sq_side.mag[i][31:0];
   end

   ncg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_vld),
      .in_side   (sq_side_mid),
      .in_num    (dv_num),
      .in_den    (sq_root[1]),
      .out_valid (dv_vld),
      .out_side  (dv_side),
      .out_quo   (dv_quo)
   );

   // clamp to one, then apply the component sign
   function automatic logic [15:0] lane_norm(input logic [QW-1:0] q, input logic neg);
      logic [QW-1:0] qc;
      logic [31:0]   m32;
      logic [31:0]   s32;
      qc  = (q > UNIT_ONE) ? UNIT_ONE : q;
      m32 = 32'(qc);
      s32 = neg ? 32'(-m32) : m32;
      return s32[15:0];
   endfunction

   // result assembly
   always_comb begin
      logic [32:0] q_rnd;
      logic [32:0] p_ss;
      logic [32:0] k_sum;
      res_in = '0;
      q_rnd  = {1'b0, dv_side.root1} + 33'(dv_side.rem1 > {2'b00, dv_side.root1});
      p_ss   = {1'b0, dv_side.sr} - q_rnd;
      k_sum  = {1'b0, dv_side.root1} + 33'd1;
      if (dv_side.hit) begin
         res_in.hit = 1'b1;
         unique case (dv_side.kind) inside
            KIND_SS, KIND_SB: begin
               if (dv_side.kind == KIND_SS) begin
                  res_in.pen = (p_ss > {1'b0, PEN_MAX}) ? PEN_MAX : p_ss[31:0];
               end else begin
                  res_in.pen = {1'b0, dv_side.as0} - k_sum[32:1];
               end
               // degenerate direction falls back to +x
               if (dv_side.zero) begin
                  res_in.nx = lane_norm(UNIT_ONE, 1'b0);
               end else begin
                  res_in.nx = lane_norm(dv_quo[0], dv_side.neg[0]);
                  res_in.ny = lane_norm(dv_quo[1], dv_side.neg[1]);
                  res_in.nz = lane_norm(dv_quo[2], dv_side.neg[2]);
               end
            end
            KIND_BB: begin
               res_in.pen = dv_side.box_pen;
               if (dv_side.box_axis == AXIS_X) begin
                  res_in.nx = lane_norm(UNIT_ONE, dv_side.box_neg);
               end else if (dv_side.box_axis == AXIS_Y) begin
                  res_in.ny = lane_norm(UNIT_ONE, dv_side.box_neg);
               end else begin
                  res_in.nz = lane_norm(UNIT_ONE, dv_side.box_neg);
               end
            end
            default: res_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_vld_ff <= 1'b0;
      end else if (en) begin
         res_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   // two-entry output queue, head in q0
   assign push = en && res_vld_ff;
   assign pop  = (cnt_ff != 2'd0) && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push && !pop) begin
         if (cnt_ff == 2'd0) begin
            q0_ff <= res_ff;
         end else begin
            q1_ff <= res_ff;
         end
      end else if (pop && !push) begin
         q0_ff <= q1_ff;
      end else if (push && pop) begin
         q0_ff <= res_ff;
      end
   end

   assign rsp_tvalid   = (cnt_ff != 2'd0);
   assign rsp_tdata    = {q0_ff.pen, q0_ff.nz, q0_ff.ny, q0_ff.nx};
   assign rsp_tuser[0] = q0_ff.hit;

endmodule

/* tb/narrowphase_contact_generator_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// narrowphase_contact_generator_core_test
// streams sphere and box pairs through the contact core and checks each beat
// ----------------------------------------------------------------------------
// a directed table (kind codes, extremes, zero offsets, centre inside box,
// axis ties) precedes random pairs, mostly scaled to be near; each accepted
// request without a result in the table is predicted here, and responses
// are compared field by field in order, with random stalls on both channels
// ----------------------------------------------------------------------------
module narrowphase_contact_generator_core_test;
   import ncg_pkg::*;

   localparam int NUM_RANDOM = 700;
   localparam int QUIET_TAIL = 100;   // last random pairs run with no idling
   localparam int WATCHDOG   = 5000;  // cycles with no beat on either side

   typedef struct {
      logic [1:0]         kind;
      logic signed [31:0] off [3];
      logic [30:0]        asz [3];
      logic [30:0]        bsz [3];
   } pair_type;

   typedef struct {
      pair_type   pair;
      bit         typed;   // expectation written into the table
      result_type res;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // offset_x, offset_y, offset_z, a_size_x, a_size_y, a_size_z,
   // b_size_x, b_size_y, b_size_z, zero fill
   logic [287:0] req_tdata = '0;
   // cmd
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   // normal_x, normal_y, normal_z, penetration
   logic [79:0]  rsp_tdata;
   // hit
   logic [0:0]   rsp_tuser;

   result_type contacts_due [$];
   int         errors = 0;
   bit         quiet = 1'b0;
   int         idle_cycles = 0;
   int         rsp_stall = 0;

   narrowphase_contact_generator_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned mag64(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   // unit vector in Q1.14 along c, +x for a zero vector
   function automatic void unit_normal(input longint c [3], output longint n [3]);
      longint unsigned m [3];
      longint unsigned mx, d, len, q;
      mx = 0;
      d  = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = mag64(c[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         n[0] = 1 << NFB;
         n[1] = 0;
         n[2] = 0;
         return;
      end
      while (mx > (64'd1 << 31)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
         mx = mx >> 1;
      end
      while (mx < (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
         mx = mx << 1;
      end
      for (int i = 0; i < 3; i++) d = d + m[i] * m[i];
      len = floor_sqrt(d);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << NFB) + len / 2) / len;
         if (q > (64'd1 << NFB)) q = 64'd1 << NFB;
         n[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic result_type predict_contact(pair_type p);
      result_type r;
      longint o [3], n [3], c [3], pd [3];
      longint unsigned as0, bs0, d, sr, q, lim, s, m, t, k, r2;
      longint pen, lo, hi;
      bit hit, over;
      int ax;
      hit = 0;
      over = 0;
      pen = 0;
      for (int i = 0; i < 3; i++) begin
         o[i] = p.off[i];
         n[i] = 0;
      end
      as0 = p.asz[0];
      bs0 = p.bsz[0];
      case (p.kind)
         KIND_SS: begin
            d  = 0;
            sr = as0 + bs0;
            for (int i = 0; i < 3; i++) d = d + mag64(o[i]) * mag64(o[i]);
            if (d <= sr * sr) begin
               q = floor_sqrt(d);
               if (d - q * q > q) q++;
               hit = 1;
               unit_normal(o, n);
               pen = (sr - q > 64'(PEN_MAX)) ? longint'(PEN_MAX) : longint'(sr - q);
            end
         end
         KIND_SB: begin
            // half-lsb units: closest box point relative to the sphere centre
            r2  = 2 * as0;
            lim = r2 * r2;
            s   = 0;
            for (int i = 0; i < 3; i++) begin
               lo   = 2 * o[i] - longint'(p.bsz[i]);
               hi   = 2 * o[i] + longint'(p.bsz[i]);
               c[i] = (lo > 0) ? lo : ((hi < 0) ? hi : 0);
            end
            for (int i = 0; i < 3; i++) begin
               if (!over) begin
                  m = mag64(c[i]);
                  if (m > r2) begin
                     over = 1;
                  end else begin
                     t = s + m * m;
                     if (t < s) over = 1;
                     else s = t;
                  end
               end
            end
            if (!over && s <= lim) begin
               k   = (floor_sqrt(s) + 1) >> 1;
               hit = 1;
               unit_normal(c, n);
               pen = longint'(as0) - longint'(k);
            end
         end
         KIND_BB: begin
            hit = 1;
            for (int i = 0; i < 3; i++) begin
               pd[i] = longint'(p.asz[i]) + longint'(p.bsz[i]) - 2 * longint'(mag64(o[i]));
               if (pd[i] < 0) hit = 0;
            end
            if (hit) begin
               // least penetration, ties fall to z
               if (pd[0] < pd[1] && pd[0] < pd[2]) ax = AXIS_X;
               else if (pd[1] < pd[0] && pd[1] < pd[2]) ax = AXIS_Y;
               else ax = AXIS_Z;
               n[ax] = (o[ax] < 0) ? -(1 << NFB) : (1 << NFB);
               pen   = (pd[ax] + 1) >>> 1;
            end
         end
         default: hit = 0;
      endcase
      r.hit = hit;
      r.nx  = hit ? n[0][15:0] : '0;
      r.ny  = hit ? n[1][15:0] : '0;
      r.nz  = hit ? n[2][15:0] : '0;
      r.pen = hit ? pen[31:0] : '0;
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic pair_type make_pair(logic [1:0] kind,
                                          logic signed [31:0] ox, oy, oz,
                                          logic [30:0] ax, ay, az, bx, by, bz);
      pair_type p;
      p.kind = kind;
      p.off[0] = ox; p.off[1] = oy; p.off[2] = oz;
      p.asz[0] = ax; p.asz[1] = ay; p.asz[2] = az;
      p.bsz[0] = bx; p.bsz[1] = by; p.bsz[2] = bz;
      return p;
   endfunction

   function automatic result_type make_res(logic hit, logic [15:0] nx, ny, nz,
                                           logic [31:0] pen);
      result_type r;
      r.hit = hit; r.nx = nx; r.ny = ny; r.nz = nz; r.pen = pen;
      return r;
   endfunction

   // random pair, mostly scaled so that the shapes are near each other
   function automatic pair_type random_pair();
      pair_type p;
      int sc;
      p.kind = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) begin
         for (int i = 0; i < 3; i++) begin
            p.off[i] = $urandom;
            p.asz[i] = 31'($urandom);
            p.bsz[i] = 31'($urandom);
         end
      end else begin
         sc = $urandom_range(2, 29);
         for (int i = 0; i < 3; i++) begin
            p.asz[i] = 31'($urandom_range(0, 1 << sc));
            p.bsz[i] = 31'($urandom_range(0, 1 << sc));
            p.off[i] = $signed($urandom_range(0, 1 << sc)) - (1 << (sc - 1));
         end
         case ($urandom_range(0, 5))
            0: for (int i = 0; i < 3; i++) p.off[i] = 0;   // concentric
            1: begin                                       // equal boxes, axis ties
               p.asz[1] = p.asz[0]; p.asz[2] = p.asz[0];
               p.bsz[1] = p.bsz[0]; p.bsz[2] = p.bsz[0];
            end
            default: ;
         endcase
      end
      return p;
   endfunction

   // drive one beat and wait for it to be taken
   task automatic send_pair(pair_type p, bit typed, result_type res);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= p.kind;
      req_tdata  <= {6'd0, p.bsz[2], p.bsz[1], p.bsz[0], p.asz[2], p.asz[1], p.asz[0],
                     p.off[2], p.off[1], p.off[0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      contacts_due.insert(contacts_due.size(), typed ? res : predict_contact(p));
   endtask

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // in-order compare of each response beat
   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (contacts_due.size() == 0) begin
            $display("%t: response beat with nothing expected, hit %0d data %h",
                     $realtime, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            exp_r = contacts_due.pop_front();
            if (rsp_tuser[0] !== exp_r.hit) begin
               $display("%t: hit expected %0d actual %0d", $realtime, exp_r.hit, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[15:0] !== exp_r.nx) begin
               $display("%t: normal_x expected %h actual %h", $realtime, exp_r.nx,
                        rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[31:16] !== exp_r.ny) begin
               $display("%t: normal_y expected %h actual %h", $realtime, exp_r.ny,
                        rsp_tdata[31:16]);
               errors++;
            end
            if (rsp_tdata[47:32] !== exp_r.nz) begin
               $display("%t: normal_z expected %h actual %h", $realtime, exp_r.nz,
                        rsp_tdata[47:32]);
               errors++;
            end
            if (rsp_tdata[79:48] !== exp_r.pen) begin
               $display("%t: penetration expected %h actual %h", $realtime, exp_r.pen,
                        rsp_tdata[79:48]);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("narrowphase_contact_generator_core_test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- main flow

   initial begin
      row_type    rows [$];
      row_type    row;
      result_type none;
      none = make_res(1'b0, 16'd0, 16'd0, 16'd0, 32'd0);

      // unknown kind is a miss
      row = '{make_pair(2'd3, 0, 0, 0, 31'h10000, 31'h10000, 31'h10000,
                        31'h10000, 31'h10000, 31'h10000), 1, none};
      rows.insert(rows.size(), row);
      // concentric spheres: +x normal, depth is the radius sum
      row = '{make_pair(KIND_SS, 0, 0, 0, 31'h10000, 0, 0, 31'h10000, 0, 0), 1,
              make_res(1'b1, 16'sd16384, 0, 0, 32'h20000)};
      rows.insert(rows.size(), row);
      // zero radii at the same point still touch
      row = '{make_pair(KIND_SS, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              make_res(1'b1, 16'sd16384, 0, 0, 32'h0)};
      rows.insert(rows.size(), row);
      // far apart points, zero radii
      row = '{make_pair(KIND_SS, 32'h7fffffff, 0, 0, 0, 0, 0, 0, 0, 0), 1, none};
      rows.insert(rows.size(), row);
      // sphere centre inside box
      row = '{make_pair(KIND_SB, 0, 0, 0, 31'h10000, 0, 0, 31'h40000, 31'h40000,
                        31'h40000), 1, make_res(1'b1, 16'sd16384, 0, 0, 32'h10000)};
      rows.insert(rows.size(), row);
      // equal boxes, all axes tie, z wins
      row = '{make_pair(KIND_BB, 0, 0, 0, 31'h20000, 31'h20000, 31'h20000,
                        31'h20000, 31'h20000, 31'h20000), 1,
              make_res(1'b1, 0, 0, 16'sd16384, 32'h20000)};
      rows.insert(rows.size(), row);
      // boxes just out of reach on x
      row = '{make_pair(KIND_BB, 32'h20001, 0, 0, 31'h20000, 31'h20000, 31'h20000,
                        31'h20000, 31'h20000, 31'h20000), 1, none};
      rows.insert(rows.size(), row);
      // predicted rows: extremes of every field and sign, and mid-range pairs
      row.typed = 0;
      row.res   = none;
      row.pair = make_pair(KIND_SS, 32'h80000000, 32'h80000000, 32'h80000000,
                           31'h7fffffff, 0, 0, 31'h7fffffff, 0, 0);
      rows.insert(rows.size(), row);
      row.pair = make_pair(KIND_SS, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                           31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                           31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      rows.insert(rows.size(), row);
      row.pair = make_pair(KIND_SS, 32'h18000, -32'sh8000, 32'h4000, 31'h10000, 0, 0,
                           31'h10000, 0, 0);
      rows.insert(rows.size(), row);
      row.pair = make_pair(KIND_SB, 32'h80000000, 32'h80000000, 32'h80000000,
                           31'h7fffffff, 0, 0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      rows.insert(rows.size(), row);
      row.pair = make_pair(KIND_SB, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                           31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      rows.insert(rows.size(), row);
      row.pair = make_pair(KIND_SB, 32'h30000, -32'sh30000, 32'h0, 31'h20000, 0, 0,
                           31'h20000, 31'h20000, 31'h20000);
      rows.insert(rows.size(), row);
      row.pair = make_pair(KIND_BB, 32'h80000000, 32'h7fffffff, 0,
                           31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                           31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      rows.insert(rows.size(), row);
      row.pair = make_pair(KIND_BB, -32'sh1000, 32'h800, -32'sh2000,
                           31'h20000, 31'h20000, 31'h20000,
                           31'h20000, 31'h20000, 31'h20000);
      rows.insert(rows.size(), row);
      row.pair = make_pair(KIND_BB, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                           31'h7fffffff, 31'h7fffffff, 31'h7fffffff,
                           31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      rows.insert(rows.size(), row);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].res);
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == NUM_RANDOM - QUIET_TAIL) quiet = 1'b1;
         send_pair(random_pair(), 0, none);
      end
      req_tvalid <= 1'b0;
      quiet = 1'b1;

      while (contacts_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("narrowphase_contact_generator_core_test passed");
      end else begin
         $display("narrowphase_contact_generator_core_test failed");
      end
      $finish;
   end

endmodule

/* narrowphase_contact_generator_core.f */
rtl/ncg_pkg.sv
rtl/ncg_front.sv
rtl/ncg_norm.sv
rtl/ncg_isqrt.sv
rtl/ncg_div.sv
rtl/narrowphase_contact_generator_core.sv
tb/narrowphase_contact_generator_core_test.sv
